### sv/atb_pkg.sv
// -----------------------------------------------------------------------------
// atb_pkg
// Shared types, constants and helpers of the transformed bounding box block.
// -----------------------------------------------------------------------------
package atb_pkg;

   // field and arithmetic widths
   localparam int DATA_W     = 32;
   localparam int FRAC_W     = 16;
   localparam int ACC_W      = 66;
   localparam int MAG_W      = 64;
   localparam int QUO_W      = 32;
   localparam int AXES       = 3;
   localparam int COLS       = 4;
   localparam int DIV_STAGES = 32;

   // corners per box
   localparam int CORNER_COUNT = 8;
   localparam int CORNER_W     = 3;

   // register port
   localparam int NUM_REGS   = 8;
   localparam int REG_SEL_W  = 3;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 64;

   // default queue depths
   localparam int DEF_IN_DEPTH  = 4;
   localparam int DEF_OUT_DEPTH = 8;

   typedef logic [CSR_DATA_W-1:0] csr_word_type;

   // identity matrix after reset
   localparam csr_word_type CSR_RESET [NUM_REGS] = '{
      64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
      64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
   };

   // [row][col] elements, signed Q16.16 each
   typedef logic [COLS-1:0][COLS-1:0][DATA_W-1:0] matrix_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] box_min_x;
      logic signed [DATA_W-1:0] box_min_y;
      logic signed [DATA_W-1:0] box_min_z;
      logic signed [DATA_W-1:0] box_max_x;
      logic signed [DATA_W-1:0] box_max_y;
      logic signed [DATA_W-1:0] box_max_z;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_min_x;
      logic signed [DATA_W-1:0] out_min_y;
      logic signed [DATA_W-1:0] out_min_z;
      logic signed [DATA_W-1:0] out_max_x;
      logic signed [DATA_W-1:0] out_max_y;
      logic signed [DATA_W-1:0] out_max_z;
      logic                     divide_fault;
   } rsp_type;

   // corner bookkeeping carried down the pipeline
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } tag_type;

   // one axis of a corner in the divider
   typedef struct packed {
      logic [MAG_W-1:0]  rem;
      logic [QUO_W-1:0]  q;
      logic [FRAC_W-1:0] nlow;
      logic              big;
      logic              neg;
   } lane_type;

   typedef struct packed {
      tag_type                  tag;
      logic                     fault;
      logic [MAG_W-1:0]         dvs;
      lane_type [AXES-1:0]      lane;
   } corner_type;

   // quotient magnitude and sign to saturated signed Q16.16
   function automatic logic [DATA_W-1:0] sat_quot(input logic big,
                                                  input logic [QUO_W-1:0] q,
                                                  input logic neg);
      logic [DATA_W-1:0] res;
      if (neg) begin
         if (big || q[QUO_W-1]) res = 32'h8000_0000;
         else                   res = 32'(-q);
      end else begin
         if (big || q >= 32'h7FFF_FFFF) res = 32'h7FFF_FFFF;
         else                           res = q;
      end
      return res;
   endfunction

endpackage

### sv/atb_queue.sv
// -----------------------------------------------------------------------------
// atb_queue
// Small register queue, first in first out.
// -----------------------------------------------------------------------------
module atb_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = mem_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (pop)
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (!push && pop) count_ff <= count_ff - 1'b1;
      end
   end
endmodule

### sv/atb_corner_seq.sv
// -----------------------------------------------------------------------------
// atb_corner_seq
// Walks the eight corners of the box at the queue head, one per cycle.
// -----------------------------------------------------------------------------
module atb_corner_seq #(
   parameter int OUT_DEPTH = atb_pkg::DEF_OUT_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            box_valid,
   input  atb_pkg::req_type                box,
   input  logic                            rsp_taken,
   output logic                            box_pop,
   output atb_pkg::tag_type                tag,
   output logic signed [atb_pkg::DATA_W-1:0] point [atb_pkg::AXES]
);
   import atb_pkg::*;

   localparam int CR_W = $clog2(OUT_DEPTH + 1);

   logic [CORNER_W-1:0] corner_ff;
   logic [CR_W-1:0]     credit_ff;
   logic                start_ok, issue, last;
   tag_type             tag_ff;
   logic signed [DATA_W-1:0] point_ff [AXES];

   // a box starts only if the result queue is sure to have room
   assign start_ok = (corner_ff != '0) || (credit_ff < CR_W'(OUT_DEPTH));
   assign issue    = box_valid && start_ok;
   assign last     = corner_ff == CORNER_W'(CORNER_COUNT - 1);
   assign box_pop  = issue && last;
   assign tag      = tag_ff;
   assign point    = point_ff;

   // corner counter and box credits
   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff <= '0;
         credit_ff <= '0;
         tag_ff    <= '0;
      end else begin
         if (issue) corner_ff <= corner_ff + 1'b1;
         if ((issue && corner_ff == '0) && !rsp_taken)      credit_ff <= credit_ff + 1'b1;
         else if (!(issue && corner_ff == '0) && rsp_taken) credit_ff <= credit_ff - 1'b1;
         tag_ff.valid <= issue;
         tag_ff.first <= corner_ff == '0;
         tag_ff.last  <= last;
      end
   end

   // corner coordinates picked by the counter bits
   always_ff @(posedge clock) begin
      point_ff[0] <= corner_ff[0] ? box.box_max_x : box.box_min_x;
      point_ff[1] <= corner_ff[1] ? box.box_max_y : box.box_min_y;
      point_ff[2] <= corner_ff[2] ? box.box_max_z : box.box_min_z;
   end
endmodule

### sv/atb_transform.sv
// -----------------------------------------------------------------------------
// atb_transform
// Multiplies one corner by the matrix and prepares the three divides.
// -----------------------------------------------------------------------------
module atb_transform (
   input  logic                              clock,
   input  logic                              reset,
   input  atb_pkg::matrix_type               matrix,
   input  atb_pkg::tag_type                  tag_in,
   input  logic signed [atb_pkg::DATA_W-1:0] point [atb_pkg::AXES],
   output atb_pkg::corner_type               corner
);
   import atb_pkg::*;

   logic signed [2*DATA_W-1:0] prod_ff [COLS][AXES];
   logic signed [DATA_W-1:0]   trans_ff [COLS];
   logic signed [ACC_W-1:0]    s01_ff [COLS];
   logic signed [ACC_W-1:0]    s2t_ff [COLS];
   logic signed [ACC_W-1:0]    acc_ff [COLS];
   logic [ACC_W-1:0]           absval [COLS];
   logic [MAG_W-1:0]           mag_ff [COLS];
   logic                       neg_ff [COLS];
   tag_type                    tag_m_ff, tag_a1_ff, tag_a2_ff, tag_g_ff;
   corner_type                 corner_ff;

   assign corner = corner_ff;

   // tag pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_m_ff  <= '0;
         tag_a1_ff <= '0;
         tag_a2_ff <= '0;
         tag_g_ff  <= '0;
      end else begin
         tag_m_ff  <= tag_in;
         tag_a1_ff <= tag_m_ff;
         tag_a2_ff <= tag_a1_ff;
         tag_g_ff  <= tag_a2_ff;
      end
   end

   // products, then two adder levels per column
   always_ff @(posedge clock) begin
      for (int c = 0; c < COLS; c++) begin
         for (int j = 0; j < AXES; j++)
            prod_ff[c][j] <= point[j] * $signed(matrix[j][c]);
         trans_ff[c] <= $signed(matrix[AXES][c]);
         s01_ff[c]   <= prod_ff[c][0] + prod_ff[c][1];
         s2t_ff[c]   <= prod_ff[c][2] + (ACC_W'(trans_ff[c]) <<< FRAC_W);
         acc_ff[c]   <= s01_ff[c] + s2t_ff[c];
      end
   end

   // magnitude and sign
   always_comb begin
      for (int c = 0; c < COLS; c++)
         absval[c] = acc_ff[c][ACC_W-1] ? ACC_W'(-acc_ff[c]) : ACC_W'(acc_ff[c]);
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < COLS; c++) begin
         mag_ff[c] <= absval[c][MAG_W-1:0];
         neg_ff[c] <= acc_ff[c][ACC_W-1];
      end
   end

   // overflow check and divider seed
   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff.tag <= '0;
      end else begin
         corner_ff.tag <= tag_g_ff;
      end
      corner_ff.fault <= mag_ff[AXES] == '0;
      corner_ff.dvs   <= mag_ff[AXES];
      for (int j = 0; j < AXES; j++) begin
         corner_ff.lane[j].rem  <= MAG_W'(mag_ff[j][MAG_W-1:FRAC_W]);
         corner_ff.lane[j].q    <= '0;
         corner_ff.lane[j].nlow <= mag_ff[j][FRAC_W-1:0];
         corner_ff.lane[j].big  <= {{FRAC_W{1'b0}}, mag_ff[j]} >=
                                   {mag_ff[AXES], {FRAC_W{1'b0}}};
         corner_ff.lane[j].neg  <= neg_ff[j] ^ neg_ff[AXES];
      end
   end
endmodule

### sv/atb_divider.sv
// -----------------------------------------------------------------------------
// atb_divider
// Pipelined restoring divider, one quotient bit per stage, three axes abreast.
// -----------------------------------------------------------------------------
module atb_divider (
   input  logic                clock,
   input  logic                reset,
   input  atb_pkg::corner_type corner_in,
   output atb_pkg::corner_type corner_out
);
   import atb_pkg::*;

   corner_type stage_ff [DIV_STAGES];
   corner_type prev     [DIV_STAGES];
   corner_type nxt      [DIV_STAGES];

   assign corner_out = stage_ff[DIV_STAGES-1];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic [MAG_W:0] rem2 [AXES];
      logic [MAG_W:0] diff [AXES];
      logic           ge   [AXES];

      if (s == 0) begin : g_head
         assign prev[s] = corner_in;
      end else begin : g_body
         assign prev[s] = stage_ff[s-1];
      end

      // shift in the next dividend bit, subtract when it fits
      always_comb begin
         nxt[s] = prev[s];
         for (int l = 0; l < AXES; l++) begin
            rem2[l] = {prev[s].lane[l].rem, prev[s].lane[l].nlow[FRAC_W-1]};
            diff[l] = rem2[l] - {1'b0, prev[s].dvs};
            ge[l]   = rem2[l] >= {1'b0, prev[s].dvs};
            nxt[s].lane[l].rem  = ge[l] ? diff[l][MAG_W-1:0] : rem2[l][MAG_W-1:0];
            nxt[s].lane[l].q    = {prev[s].lane[l].q[QUO_W-2:0], ge[l]};
            nxt[s].lane[l].nlow = {prev[s].lane[l].nlow[FRAC_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[s].tag <= '0;
         end else begin
            stage_ff[s].tag <= nxt[s].tag;
         end
         stage_ff[s].fault <= nxt[s].fault;
         stage_ff[s].dvs   <= nxt[s].dvs;
         stage_ff[s].lane  <= nxt[s].lane;
      end
   end
endmodule

### sv/atb_reduce.sv
// -----------------------------------------------------------------------------
// atb_reduce
// Saturates the quotients and folds the corners into one min and max per box.
// -----------------------------------------------------------------------------
module atb_reduce (
   input  logic                clock,
   input  logic                reset,
   input  atb_pkg::corner_type corner,
   output logic                push,
   output atb_pkg::rsp_type    result
);
   import atb_pkg::*;

   tag_type                  tag_ff;
   logic                     cfault_ff;
   logic signed [DATA_W-1:0] val_ff  [AXES];
   logic signed [DATA_W-1:0] min_ff  [AXES];
   logic signed [DATA_W-1:0] max_ff  [AXES];
   logic signed [DATA_W-1:0] min_in  [AXES];
   logic signed [DATA_W-1:0] max_in  [AXES];
   logic                     any_ff, fault_ff, any_in, fault_in, any_eff;

   // saturation stage
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= corner.tag;
      end
      cfault_ff <= corner.fault;
      for (int j = 0; j < AXES; j++)
         val_ff[j] <= $signed(sat_quot(corner.lane[j].big, corner.lane[j].q,
                                       corner.lane[j].neg));
   end

   // running min and max, restarted on the first corner
   always_comb begin
      any_eff  = !tag_ff.first && any_ff;
      any_in   = any_eff;
      fault_in = !tag_ff.first && fault_ff;
      for (int j = 0; j < AXES; j++) begin
         min_in[j] = tag_ff.first ? '0 : min_ff[j];
         max_in[j] = tag_ff.first ? '0 : max_ff[j];
      end
      if (cfault_ff) begin
         fault_in = 1'b1;
      end else begin
         any_in = 1'b1;
         for (int j = 0; j < AXES; j++) begin
            if (!any_eff || val_ff[j] < min_in[j]) min_in[j] = val_ff[j];
            if (!any_eff || val_ff[j] > max_in[j]) max_in[j] = val_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_ff   <= 1'b0;
         fault_ff <= 1'b0;
      end else if (tag_ff.valid) begin
         any_ff   <= any_in;
         fault_ff <= fault_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tag_ff.valid) begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   // finished box goes to the result queue
   assign push                = tag_ff.valid && tag_ff.last;
   assign result.out_min_x    = min_in[0];
   assign result.out_min_y    = min_in[1];
   assign result.out_min_z    = min_in[2];
   assign result.out_max_x    = max_in[0];
   assign result.out_max_y    = max_in[1];
   assign result.out_max_z    = max_in[2];
   assign result.divide_fault = fault_in;
endmodule

### sv/aabb_transform_bounds.sv
// -----------------------------------------------------------------------------
// aabb_transform_bounds
// Transformed axis-aligned bounding box from the eight box corners.
// -----------------------------------------------------------------------------
// Each box item is queued on entry; the corner sequencer then issues its eight
// corners, one per cycle, into a shared pipeline of twelve 32x32 multipliers,
// a two-level adder, and a 32-stage restoring divider for x, y and z. A new
// box may start once the last corner of the one before is issued, so boxes
// overlap. A box passes the input queue, the sequencer, 5 transform stages,
// the divider and saturation; its result is pushed to the result queue as its
// last corner is folded in. Boxes only enter the pipeline when the result
// queue has room reserved, so the pipeline never stalls. While results wait
// on rsp_ready, new boxes still start until OUT_DEPTH boxes hold room. The
// user must write matrix registers on the csr port only while the block is
// idle, which the block does not enforce; indexes above 7 are ignored.
// -----------------------------------------------------------------------------
module aabb_transform_bounds #(
   parameter int IN_DEPTH  = atb_pkg::DEF_IN_DEPTH,
   parameter int OUT_DEPTH = atb_pkg::DEF_OUT_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  atb_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output atb_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [atb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [atb_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import atb_pkg::*;

   csr_word_type             csr_ff [NUM_REGS];
   matrix_type               matrix;
   logic                     in_full, in_empty, box_pop;
   logic [$bits(req_type)-1:0] box_bits;
   logic [$bits(rsp_type)-1:0] out_bits;
   req_type                  box;
   tag_type                  tag;
   logic signed [DATA_W-1:0] point [AXES];
   corner_type               corner_t, corner_d;
   logic                     res_push, out_full, out_empty, rsp_taken;
   rsp_type                  result;

   // matrix registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CSR_RESET;
      end else if (csr_we && csr_index < CSR_IDX_W'(NUM_REGS)) begin
         csr_ff[csr_index[REG_SEL_W-1:0]] <= csr_wdata;
      end
   end

   for (genvar r = 0; r < COLS; r++) begin : g_row
      for (genvar c = 0; c < COLS; c++) begin : g_col
         assign matrix[r][c] = csr_ff[2*r + c/2][(c%2)*DATA_W +: DATA_W];
      end
   end

   // input queue
   assign req_ready = !in_full;

   atb_queue #(.WIDTH($bits(req_type)), .DEPTH(IN_DEPTH)) u_in_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && req_ready),
      .push_data (req_data),
      .pop       (box_pop),
      .pop_data  (box_bits),
      .full      (in_full),
      .empty     (in_empty)
   );

   assign box = req_type'(box_bits);

   atb_corner_seq #(.OUT_DEPTH(OUT_DEPTH)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .box_valid (!in_empty),
      .box       (box),
      .rsp_taken (rsp_taken),
      .box_pop   (box_pop),
      .tag       (tag),
      .point     (point)
   );

   atb_transform u_transform (
      .clock  (clock),
      .reset  (reset),
      .matrix (matrix),
      .tag_in (tag),
      .point  (point),
      .corner (corner_t)
   );

   atb_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .corner_in  (corner_t),
      .corner_out (corner_d)
   );

   atb_reduce u_reduce (
      .clock  (clock),
      .reset  (reset),
      .corner (corner_d),
      .push   (res_push),
      .result (result)
   );

   // result queue, room reserved by the sequencer
   assign rsp_taken = rsp_valid && rsp_ready;
   assign rsp_valid = !out_empty;
   assign rsp_data  = rsp_type'(out_bits);

   atb_queue #(.WIDTH($bits(rsp_type)), .DEPTH(OUT_DEPTH)) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (result),
      .pop       (rsp_taken),
      .pop_data  (out_bits),
      .full      (out_full),
      .empty     (out_empty)
   );

   // room is reserved per box, so a push never meets a full queue
   logic unused_full;
   assign unused_full = out_full;
endmodule

### sv/atb_checker.sv
// -----------------------------------------------------------------------------
// atb_checker
// Port-level checks of the transformed bounding box block.
// -----------------------------------------------------------------------------
module atb_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input atb_pkg::req_type               req_data,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input atb_pkg::rsp_type               rsp_data,
   input logic                           csr_we,
   input logic [atb_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [atb_pkg::CSR_DATA_W-1:0] csr_wdata
);
   logic [7:0] outstanding_ff;
   logic       req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // items accepted and not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else if (req_take && !rsp_take) begin
         outstanding_ff <= outstanding_ff + 1'b1;
      end else if (!req_take && rsp_take) begin
         outstanding_ff <= outstanding_ff - 1'b1;
      end
   end

   // no result out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // every result answers an accepted item
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> outstanding_ff != 8'd0)
      else $error("result without an accepted item");

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // bounds are ordered on every axis
   a_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.out_min_x <= rsp_data.out_max_x &&
                    rsp_data.out_min_y <= rsp_data.out_max_y &&
                    rsp_data.out_min_z <= rsp_data.out_max_z)
      else $error("result minimum above maximum");
endmodule

bind aabb_transform_bounds atb_checker u_checker (.*);

### dv/aabb_transform_bounds_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// aabb_transform_bounds_tb
// Sends boxes through the transformed bounding box block under several matrix
// settings and idle patterns. Every result is compared field by field against
// an in-bench prediction of the eight corner transforms and divides.
// -----------------------------------------------------------------------------
module aabb_transform_bounds_tb;
   import atb_pkg::*;

   localparam int DRAIN_CYCLES = 120;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // bench copy of the matrix registers
   logic [CSR_DATA_W-1:0] matrix_regs [NUM_REGS];
   rsp_type               bounds_queue [$];
   int                    send_idle_pct;
   int                    recv_stall_pct;
   int                    error_count;
   int                    box_count;
   int                    bounds_count;
   int                    fault_count;

   aabb_transform_bounds dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // overall time limit
   initial begin
      #20ms;
      $display("aabb_transform_bounds_tb: FAIL");
      $finish;
   end

   // matrix element (row, col), signed Q16.16
   function automatic logic signed [63:0] elem(int r, int c);
      logic [63:0] w;
      w = matrix_regs[2 * r + c / 2];
      return (c % 2) ? 64'(signed'(w[63:32])) : 64'(signed'(w[31:0]));
   endfunction

   // divided corner component, truncated toward zero and saturated
   function automatic logic signed [31:0] divide_sat(logic signed [95:0] n,
                                                     logic signed [95:0] d);
      logic [95:0] nm, dm, q;
      logic        neg;
      nm  = n[95] ? -n : n;
      dm  = d[95] ? -d : d;
      q   = (nm << 16) / dm;
      neg = (n[95] != d[95]) && (q != 0);
      if (neg) return (q >= 96'h8000_0000) ? 32'h8000_0000 : 32'(-q);
      return (q >= 96'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(q);
   endfunction

   // expected bounds of the transformed box
   function automatic rsp_type transform_bounds(req_type b);
      rsp_type                 r;
      logic signed [31:0]      lo [3], hi [3], mn [3], mx [3], v;
      logic signed [95:0]      acc [4];
      logic signed [63:0]      p [3];
      logic                    any;
      lo = '{b.box_min_x, b.box_min_y, b.box_min_z};
      hi = '{b.box_max_x, b.box_max_y, b.box_max_z};
      mn = '{0, 0, 0};
      mx = '{0, 0, 0};
      any = 1'b0;
      r = '0;
      for (int k = 0; k < CORNER_COUNT; k++) begin
         for (int j = 0; j < 3; j++) p[j] = ((k >> j) & 1) ? hi[j] : lo[j];
         for (int c = 0; c < 4; c++) begin
            acc[c] = 96'(elem(3, c)) <<< 16;
            for (int j = 0; j < 3; j++) acc[c] += 96'(p[j] * elem(j, c));
         end
         if (acc[3] == 0) begin
            r.divide_fault = 1'b1;
            continue;
         end
         for (int j = 0; j < 3; j++) begin
            v = divide_sat(acc[j], acc[3]);
            if (!any || v < mn[j]) mn[j] = v;
            if (!any || v > mx[j]) mx[j] = v;
         end
         any = 1'b1;
      end
      r.out_min_x = mn[0];
      r.out_min_y = mn[1];
      r.out_min_z = mn[2];
      r.out_max_x = mx[0];
      r.out_max_y = mx[1];
      r.out_max_z = mx[2];
      return r;
   endfunction

   // send one box and record its expected bounds
   task automatic send_box(req_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bounds_queue.push_back(transform_bounds(b));
      box_count++;
      @(negedge clock);
   endtask

   // register write while idle
   task automatic write_reg(int idx, logic [63:0] val);
      csr_we    = 1'b1;
      csr_index = CSR_IDX_W'(idx);
      csr_wdata = val;
      if (idx < NUM_REGS) matrix_regs[idx] = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (bounds_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_q(int mag_bits);
      return 32'($signed($urandom) >>> (32 - mag_bits));
   endfunction

   function automatic req_type rand_box(int mag_bits);
      req_type b;
      b.box_min_x = rand_q(mag_bits);
      b.box_min_y = rand_q(mag_bits);
      b.box_min_z = rand_q(mag_bits);
      b.box_max_x = rand_q(mag_bits);
      b.box_max_y = rand_q(mag_bits);
      b.box_max_z = rand_q(mag_bits);
      return b;
   endfunction

   // element packing for a pair of columns
   function automatic logic [63:0] pair(logic [31:0] c0, logic [31:0] c1);
      return {c1, c0};
   endfunction

   // reset matrix values
   task automatic load_identity();
      for (int i = 0; i < NUM_REGS; i++) write_reg(i, CSR_RESET[i]);
   endtask

   // random affine matrix, w column kept simple unless projective is asked
   task automatic load_random(bit projective);
      for (int r = 0; r < 4; r++) begin
         write_reg(2 * r, pair(rand_q(19), rand_q(19)));
         if (projective)
            write_reg(2 * r + 1, pair(rand_q(19), rand_q(18)));
         else
            write_reg(2 * r + 1, pair(rand_q(19), (r == 3) ? 32'h0001_0000 : 32'h0));
      end
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (bounds_queue.size() == 0) begin
            $display("%0t: unexpected bounds item %h", $time, rsp_data);
            error_count++;
         end else begin
            e = bounds_queue.pop_front();
            bounds_count++;
            if (e.divide_fault) fault_count++;
            if (e.out_min_x !== rsp_data.out_min_x || e.out_min_y !== rsp_data.out_min_y ||
                e.out_min_z !== rsp_data.out_min_z || e.out_max_x !== rsp_data.out_max_x ||
                e.out_max_y !== rsp_data.out_max_y || e.out_max_z !== rsp_data.out_max_z ||
                e.divide_fault !== rsp_data.divide_fault) begin
               $display("%0t: mismatch expected %h actual %h", $time, e, rsp_data);
               error_count++;
            end
         end
      end
   end

   // receiver stall
   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   // identity, extremes and min above max, then saturation, zero w and all ones
   task automatic test_directed();
      req_type b;
      logic [31:0] ext [4];
      ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
      for (int i = 0; i < 4; i++) begin
         b = '{ext[i], ext[i], ext[i], ext[3 - i], ext[3 - i], ext[3 - i]};
         send_box(b);
      end
      send_box('{32'h0001_0000, 32'hFFFE_0000, 32'h0, 32'hFFFF_0000, 32'h0003_0000,
                 32'h0});
      wait_idle();
      // large scale drives quotients into saturation
      write_reg(0, pair(32'h7FFF_FFFF, 32'h8000_0000));
      write_reg(3, pair(32'h8000_0000, 32'h7FFF_FFFF));
      write_reg(15, 64'hFFFF_FFFF_FFFF_FFFF);
      for (int i = 0; i < 4; i++) send_box(rand_box(32));
      send_box('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000});
      wait_idle();
      // w term zero everywhere, then w following x: nonzero for the first box, zero for the second
      for (int i = 0; i < NUM_REGS; i++) write_reg(i, 64'h0);
      send_box(rand_box(24));
      wait_idle();
      write_reg(1, pair(32'h0, 32'h0001_0000));
      write_reg(0, pair(32'h0001_0000, 32'h0));
      send_box('{32'hFFFF_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0002_0000, 32'h0});
      send_box('{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
      wait_idle();
      // all ones in every register
      for (int i = 0; i < NUM_REGS; i++) write_reg(i, 64'hFFFF_FFFF_FFFF_FFFF);
      send_box(rand_box(20));
      send_box(rand_box(32));
      wait_idle();
   endtask

   // random boxes over a random matrix under one idle pattern
   task automatic test_random(int count, int idle_pct, int stall_pct, bit projective);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      load_random(projective);
      for (int i = 0; i < count; i++)
         send_box(rand_box(($urandom_range(9) == 0) ? 32 : $urandom_range(18, 24)));
      wait_idle();
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_ready      = 1'b0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      error_count    = 0;
      box_count      = 0;
      bounds_count   = 0;
      fault_count    = 0;
      for (int i = 0; i < NUM_REGS; i++) matrix_regs[i] = CSR_RESET[i];
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      load_identity();
      test_random(150, 0, 0, 1'b0);
      test_random(150, 84, 0, 1'b1);
      test_random(150, 0, 84, 1'b0);
      test_random(150, 26, 26, 1'b1);
      test_random(120, 0, 0, 1'b1);

      $display("covered %0d boxes, %0d bounds checked, %0d with divide fault",
               box_count, bounds_count, fault_count);
      if (error_count == 0) $display("aabb_transform_bounds_tb: PASS");
      else $display("aabb_transform_bounds_tb: FAIL");
      $finish;
   end

endmodule

### filelist.f
sv/atb_pkg.sv
sv/atb_queue.sv
sv/atb_corner_seq.sv
sv/atb_transform.sv
sv/atb_divider.sv
sv/atb_reduce.sv
sv/aabb_transform_bounds.sv
sv/atb_checker.sv
dv/aabb_transform_bounds_tb.sv
